FILE: rtl/directed_graph_cycle_detector_macros.svh
// Assertion macros shared by the cycle detector modules.
`ifndef DIRECTED_GRAPH_CYCLE_DETECTOR_MACROS_SVH
`define DIRECTED_GRAPH_CYCLE_DETECTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DGCD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DGCD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/dgcd_pkg.sv
// Shared request codes and controller/datapath interface types for the cycle detector.
package dgcd_pkg;

  // Width of the vertex index fields on the input channel.
  localparam int VERTEX_FIELD_W = 5;

  // Request codes carried by req_type.
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_CHECK = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic add_edge;     // store the edge on the input ports
    logic clear_graph;  // drop all rows, visited and on-path marks
    logic root_reset;   // restart the root scan at vertex zero
    logic root_next;    // move on to the next root
    logic start;        // open a search at the current root
    logic step;         // advance the edge cursor by one
    logic push;         // descend into the vertex under the cursor
    logic pop;          // leave the current vertex, fetch its parent
    logic reload;       // make the fetched parent the current vertex
  } dgcd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic root_end;     // every root has been tried
    logic root_seen;    // current root was already visited
    logic cur_end;      // cursor is past the last vertex
    logic hit;          // the edge under the cursor exists
    logic hit_path;     // its target is on the current path
    logic hit_seen;     // its target was already visited
    logic last_level;   // only the root is on the path
    logic depth_full;   // the path holds every vertex
  } dgcd_sts_t;

endpackage

FILE: rtl/dgcd_datapath.sv
// Datapath: adjacency memory, search marks, path stack and cursors.
`include "directed_graph_cycle_detector_macros.svh"

module dgcd_datapath import dgcd_pkg::*; #(
  parameter int VERTICES = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [VERTEX_FIELD_W-1:0] src_vertex,
  input  logic [VERTEX_FIELD_W-1:0] dst_vertex,
  input  dgcd_cmd_t                 cmd,
  output dgcd_sts_t                 sts
);

  localparam int VW = (VERTICES > 1) ? $clog2(VERTICES) : 1;
  localparam int CW = $clog2(VERTICES + 1);
  localparam int EW = VW + CW;
  localparam logic [CW-1:0] VCOUNT = CW'(VERTICES);
  localparam logic [VERTEX_FIELD_W+1:0] VLIMIT = (VERTEX_FIELD_W + 2)'(VERTICES);

  // Adjacency rows; a row whose valid bit is low reads as all zero.
  logic [VERTICES-1:0] adj_mem [VERTICES];
  logic [VERTICES-1:0] row_valid_r;
  logic [VERTICES-1:0] row_r;

  // Path stack entries hold the parent vertex and its resume cursor.
  logic [EW-1:0]       stack_mem [VERTICES];
  logic [EW-1:0]       stk_q_r;

  logic [VERTICES-1:0] visited_r;
  logic [VERTICES-1:0] onpath_r;
  logic [VW-1:0]       top_v_r;
  logic [CW-1:0]       cur_r;
  logic [CW-1:0]       depth_r;
  logic [CW-1:0]       root_r;

  logic [VW-1:0]       src_idx;
  logic [VW-1:0]       dst_idx;
  logic                in_range;
  logic [VERTICES-1:0] dst_onehot;
  logic [VW-1:0]       cur_idx;
  logic [VW-1:0]       root_idx;
  logic [VW-1:0]       stk_v;
  logic [CW-1:0]       stk_c;
  logic [VW-1:0]       rd_addr;
  logic                rd_en;

  assign src_idx  = VW'(src_vertex);
  assign dst_idx  = VW'(dst_vertex);
  assign in_range = ({2'b00, src_vertex} < VLIMIT) && ({2'b00, dst_vertex} < VLIMIT);
  assign cur_idx  = cur_r[VW-1:0];
  assign root_idx = root_r[VW-1:0];
  assign stk_v    = stk_q_r[EW-1:CW];
  assign stk_c    = stk_q_r[CW-1:0];

  // One-hot image of the destination, used to open a fresh row.
  always_comb begin
    dst_onehot          = '0;
    dst_onehot[dst_idx] = 1'b1;
  end

  // Row read address: the new root, the vertex being entered or the parent.
  always_comb begin
    if (cmd.start) begin
      rd_addr = root_idx;
    end else if (cmd.push) begin
      rd_addr = cur_idx;
    end else begin
      rd_addr = stk_v;
    end
  end
  assign rd_en = cmd.start | cmd.push | cmd.reload;

  // Status toward the controller.
  always_comb begin
    sts.root_end   = (root_r == VCOUNT);
    sts.root_seen  = !sts.root_end && visited_r[root_idx];
    sts.cur_end    = (cur_r == VCOUNT);
    sts.hit        = !sts.cur_end && row_r[cur_idx];
    sts.hit_path   = onpath_r[cur_idx];
    sts.hit_seen   = visited_r[cur_idx];
    sts.last_level = (depth_r == CW'(1));
    sts.depth_full = (depth_r == VCOUNT);
  end

  // Row valid bits: cleared at once by reset and after every check.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else if (cmd.clear_graph) begin
      row_valid_r <= '0;
    end else if (cmd.add_edge && in_range) begin
      row_valid_r[src_idx] <= 1'b1;
    end
  end

  // Adjacency memory write; a stale row is replaced rather than merged.
  always_ff @(posedge clk) begin
    if (cmd.add_edge && in_range) begin
      if (row_valid_r[src_idx]) begin
        adj_mem[src_idx][dst_idx] <= 1'b1;
      end else begin
        adj_mem[src_idx] <= dst_onehot;
      end
    end
  end

  // Registered row read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      row_r <= row_valid_r[rd_addr] ? adj_mem[rd_addr] : '0;
    end
  end

  // Path stack: save the parent on descent, fetch it back on return.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack_mem[VW'(depth_r - CW'(1))] <= {top_v_r, cur_r + CW'(1)};
    end
    if (cmd.pop) begin
      stk_q_r <= stack_mem[VW'(depth_r - CW'(2))];
    end
  end

  // Search state: marks, current vertex, cursor, depth and root.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      visited_r <= '0;
      onpath_r  <= '0;
      top_v_r   <= '0;
      cur_r     <= '0;
      depth_r   <= '0;
      root_r    <= '0;
    end else begin
      if (cmd.clear_graph) begin
        visited_r <= '0;
        onpath_r  <= '0;
        depth_r   <= '0;
      end
      if (cmd.root_reset) begin
        root_r <= '0;
      end else if (cmd.root_next) begin
        root_r <= root_r + CW'(1);
      end
      if (cmd.start) begin
        visited_r[root_idx] <= 1'b1;
        onpath_r[root_idx]  <= 1'b1;
        top_v_r             <= root_idx;
        cur_r               <= '0;
        depth_r             <= CW'(1);
      end else if (cmd.push) begin
        visited_r[cur_idx] <= 1'b1;
        onpath_r[cur_idx]  <= 1'b1;
        top_v_r            <= cur_idx;
        cur_r              <= '0;
        depth_r            <= depth_r + CW'(1);
      end else if (cmd.step) begin
        cur_r <= cur_r + CW'(1);
      end else if (cmd.pop) begin
        onpath_r[top_v_r] <= 1'b0;
        depth_r           <= depth_r - CW'(1);
      end else if (cmd.reload) begin
        top_v_r <= stk_v;
        cur_r   <= stk_c;
      end
    end
  end

  // Path marks must track depth and visited marks; pushes must be fresh.
  `DGCD_ASSERT_IMP(a_path_count, clk, rst_n, 1'b1, $countones(onpath_r) == int'(depth_r), "path marks disagree with depth")
  `DGCD_ASSERT_IMP(a_path_visited, clk, rst_n, 1'b1, (onpath_r & ~visited_r) == '0, "vertex on path but not visited")
  `DGCD_ASSERT_IMP(a_push_fresh, clk, rst_n, cmd.push, !sts.hit_seen && !sts.depth_full, "descent into visited vertex")

endmodule

FILE: rtl/dgcd_controller.sv
// Controller: request handshake, search sequencing and the result register.
`include "directed_graph_cycle_detector_macros.svh"

module dgcd_controller import dgcd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      in_req_type,
  output logic      out_valid,
  input  logic      out_ready,
  output logic      out_has_cycle,
  output dgcd_cmd_t cmd,
  input  dgcd_sts_t sts
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROOT,
    ST_SCAN,
    ST_POP,
    ST_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_has_cycle_r;
  logic   found_r;
  logic   found_nxt;
  logic   slot_free;
  logic   accept;

  assign in_ready      = (state_r == ST_IDLE);
  assign accept        = in_valid && in_ready;
  assign slot_free     = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_has_cycle = out_has_cycle_r;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    found_nxt = found_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_req_type == REQ_ADD) begin
            cmd.add_edge = 1'b1;
          end else begin
            cmd.root_reset = 1'b1;
            found_nxt      = 1'b0;
            state_nxt      = ST_ROOT;
          end
        end
      end
      ST_ROOT: begin
        if (sts.root_end) begin
          state_nxt = ST_DONE;
        end else if (sts.root_seen) begin
          cmd.root_next = 1'b1;
        end else begin
          cmd.start = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.cur_end) begin
          cmd.pop = 1'b1;
          if (sts.last_level) begin
            cmd.root_next = 1'b1;
            state_nxt     = ST_ROOT;
          end else begin
            state_nxt = ST_POP;
          end
        end else begin
          cmd.step = 1'b1;
          if (sts.hit) begin
            if (sts.hit_path) begin
              found_nxt = 1'b1;
              state_nxt = ST_DONE;
            end else if (!sts.hit_seen && !sts.depth_full) begin
              cmd.push = 1'b1;
            end
          end
        end
      end
      ST_POP: begin
        cmd.reload = 1'b1;
        state_nxt  = ST_SCAN;
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.clear_graph = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, search verdict and the result word register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      found_r         <= 1'b0;
      out_valid_r     <= 1'b0;
      out_has_cycle_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      found_r <= found_nxt;
      if (state_r == ST_DONE && slot_free) begin
        out_valid_r     <= 1'b1;
        out_has_cycle_r <= found_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `DGCD_ASSERT_NXT(a_check_starts, clk, rst_n, accept && in_req_type == REQ_CHECK, state_r == ST_ROOT, "check word did not start a search")
  `DGCD_ASSERT_NXT(a_done_reports, clk, rst_n, state_r == ST_DONE && slot_free, out_valid_r && state_r == ST_IDLE, "finished check did not report")
  `DGCD_ASSERT_NXT(a_pop_reloads, clk, rst_n, state_r == ST_POP, state_r == ST_SCAN, "parent reload did not resume scanning")

endmodule

FILE: rtl/directed_graph_cycle_detector.sv
// Top level of the directed graph cycle detector.
// An add word (req_type 0) sets edge src_vertex -> dst_vertex in the adjacency memory, and
// edges stream in at one word per cycle; edges naming a vertex at or above VERTICES are
// dropped. A check word (req_type 1) runs a depth-first search from every unvisited root
// and returns one word whose has_cycle is 1 when any directed cycle exists (self-loops
// included), then empties the graph. The search examines one adjacency bit per cycle
// through the single row read port while it scans; leaving a vertex, trying a root and
// returning to a parent are separate steps. A check holds the input until its search ends
// and any previous result has left the output, and it ends early on the first cycle found.
// No word is taken while a check runs; add words are taken while a finished result still
// waits on the output. The graph is emptied at reset and after each check through per-row
// valid bits, so no clearing pass is needed.
module directed_graph_cycle_detector import dgcd_pkg::*; #(
  parameter int VERTICES = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_req_type,
  input  logic [VERTEX_FIELD_W-1:0] in_src_vertex,
  input  logic [VERTEX_FIELD_W-1:0] in_dst_vertex,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_has_cycle
);

  dgcd_cmd_t cmd;
  dgcd_sts_t sts;

  // Sequencer and result register.
  dgcd_controller u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_has_cycle (out_has_cycle),
    .cmd           (cmd),
    .sts           (sts)
  );

  // Graph storage and search state.
  dgcd_datapath #(
    .VERTICES (VERTICES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .src_vertex (in_src_vertex),
    .dst_vertex (in_dst_vertex),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

FILE: bench/directed_graph_cycle_detector_test.sv
// Self-checking testbench for the directed graph cycle detector.
module directed_graph_cycle_detector_test import dgcd_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int VERTEX_COUNT   = 32;
  localparam int RANDOM_WORDS   = 1450;
  localparam int CALM_TAIL      = 150;
  localparam int DRAIN_CYCLES   = 1200;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int REPORT_LIMIT   = 10;

  typedef logic [VERTEX_FIELD_W-1:0] vertex_t;

  // One input word plus a flag that holds it back until all answers are in.
  typedef struct {
    logic    req_type;
    vertex_t src;
    vertex_t dst;
    bit      wait_drain;
  } graph_word_t;

  logic    clk = 1'b0;
  logic    rst_n;
  logic    in_valid = 1'b0;
  logic    in_ready;
  logic    in_req_type = REQ_ADD;
  vertex_t in_src_vertex = '0;
  vertex_t in_dst_vertex = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  logic    out_has_cycle;

  graph_word_t pending_words[$];
  bit          cycle_answers[$];
  logic [VERTEX_COUNT-1:0] edge_rows [VERTEX_COUNT];

  int words_total = 0;
  int words_sent = 0;
  int mismatches = 0;
  int send_gap = 0;
  int accept_stall = 0;
  int quiet_cycles = 0;

  directed_graph_cycle_detector #(.VERTICES(VERTEX_COUNT)) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_src_vertex (in_src_vertex),
    .in_dst_vertex (in_dst_vertex),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_has_cycle (out_has_cycle)
  );

  always #5 clk = ~clk;

  // Peel off vertices with no edge into the remaining set; a cycle is whatever survives.
  function automatic bit graph_has_cycle();
    logic [VERTEX_COUNT-1:0] alive;
    bit changed;
    alive = '1;
    changed = 1'b1;
    while (changed) begin
      changed = 1'b0;
      for (int v = 0; v < VERTEX_COUNT; v++) begin
        if (alive[v] && (edge_rows[v] & alive) == '0) begin
          alive[v] = 1'b0;
          changed = 1'b1;
        end
      end
    end
    return alive != '0;
  endfunction

  task automatic queue_add(input int src, input int dst, input bit wait_drain = 1'b0);
    graph_word_t w;
    w.req_type = REQ_ADD;
    w.src = vertex_t'(src);
    w.dst = vertex_t'(dst);
    w.wait_drain = wait_drain;
    pending_words.push_back(w);
  endtask

  task automatic queue_check(input bit wait_drain = 1'b0);
    graph_word_t w;
    w.req_type = REQ_CHECK;
    w.src = vertex_t'($urandom());
    w.dst = vertex_t'($urandom());
    w.wait_drain = wait_drain;
    pending_words.push_back(w);
  endtask

  // Build one random graph and close it with a check word.
  task automatic queue_random_graph(input bit wait_drain);
    int order[VERTEX_COUNT];
    int srcs[$];
    int dsts[$];
    int kind, count, i, j, k, tmp;
    kind = $urandom_range(0, 9);
    for (int v = 0; v < VERTEX_COUNT; v++) order[v] = v;
    for (int v = VERTEX_COUNT - 1; v > 0; v--) begin
      k = $urandom_range(0, v);
      tmp = order[v];
      order[v] = order[k];
      order[k] = tmp;
    end
    if (kind <= 4) begin
      // Edges that follow a random vertex order, so the graph starts out acyclic.
      if ($urandom_range(0, 2) == 0) begin
        for (i = 0; i < VERTEX_COUNT - 1; i++) begin
          srcs.push_back(order[i]);
          dsts.push_back(order[i + 1]);
        end
      end
      count = $urandom_range(0, 24);
      repeat (count) begin
        i = $urandom_range(0, VERTEX_COUNT - 2);
        j = $urandom_range(i + 1, VERTEX_COUNT - 1);
        srcs.push_back(order[i]);
        dsts.push_back(order[j]);
      end
      // Optional back edge, which may or may not close a cycle.
      if ($urandom_range(0, 1) == 1) begin
        i = $urandom_range(0, VERTEX_COUNT - 1);
        j = $urandom_range(i, VERTEX_COUNT - 1);
        k = $urandom_range(0, srcs.size());
        srcs.insert(k, order[j]);
        dsts.insert(k, order[i]);
      end
    end else begin
      count = (kind <= 7) ? $urandom_range(0, 10) : $urandom_range(10, 50);
      repeat (count) begin
        srcs.push_back($urandom_range(0, VERTEX_COUNT - 1));
        dsts.push_back($urandom_range(0, VERTEX_COUNT - 1));
      end
    end
    // Repeat an edge now and then; the second load must change nothing.
    if (srcs.size() != 0 && $urandom_range(0, 3) == 0) begin
      k = $urandom_range(0, srcs.size() - 1);
      srcs.push_back(srcs[k]);
      dsts.push_back(dsts[k]);
    end
    for (i = 0; i < srcs.size(); i++) queue_add(srcs[i], dsts[i], wait_drain && i == 0);
    // An empty graph carries the hold on its check word instead.
    queue_check(wait_drain && srcs.size() == 0);
  endtask

  task automatic note_failure(input string what);
    if (mismatches < REPORT_LIMIT) $display("ERROR at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // Driver: presents queued words, mirrors each accepted one into the graph copy.
  always @(posedge clk) begin
    graph_word_t next_word;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
      for (int v = 0; v < VERTEX_COUNT; v++) edge_rows[v] = '0;
    end else begin
      if (in_valid && in_ready) begin
        words_sent++;
        if (in_req_type == REQ_ADD) begin
          edge_rows[in_src_vertex][in_dst_vertex] = 1'b1;
        end else begin
          cycle_answers.push_back(graph_has_cycle());
          for (int v = 0; v < VERTEX_COUNT; v++) edge_rows[v] = '0;
        end
      end
      if (!(in_valid && !in_ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0 &&
                     !(pending_words[0].wait_drain && cycle_answers.size() != 0)) begin
          if (pending_words.size() >= CALM_TAIL && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(0, 2);
            in_valid <= 1'b0;
          end else begin
            next_word = pending_words.pop_front();
            in_valid <= 1'b1;
            in_req_type <= next_word.req_type;
            in_src_vertex <= next_word.src;
            in_dst_vertex <= next_word.dst;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each result word with the oldest answer and stalls at random.
  always @(posedge clk) begin
    bit want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      accept_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (cycle_answers.size() == 0) begin
          note_failure($sformatf("result word has_cycle=%0b with no check pending",
                                 out_has_cycle));
        end else begin
          want = cycle_answers.pop_front();
          if (out_has_cycle !== want)
            note_failure($sformatf("has_cycle expected %0b, got %0b", want, out_has_cycle));
        end
      end
      if (accept_stall > 0) begin
        accept_stall--;
        out_ready <= 1'b0;
      end else if (pending_words.size() >= CALM_TAIL && $urandom_range(0, 4) == 0) begin
        accept_stall = $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles in which no word moves on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;

    // Empty graph, then self-loops at both ends of the vertex range.
    queue_check();
    queue_add(0, 0);
    queue_check();
    queue_add(31, 31);
    queue_check();
    // Two-vertex cycle between the extreme vertices.
    queue_add(0, 31);
    queue_add(31, 0);
    queue_check();
    // Duplicate edge in an acyclic graph.
    queue_add(0, 31);
    queue_add(0, 31);
    queue_add(31, 30);
    queue_check();
    // Three-vertex cycle with alternating index bits.
    queue_add(5, 10);
    queue_add(10, 21);
    queue_add(21, 5);
    queue_check();
    // Diamond: two paths to one vertex, still no cycle.
    queue_add(1, 2);
    queue_add(1, 3);
    queue_add(2, 4);
    queue_add(3, 4);
    queue_check();

    // Random graphs; the first one waits for every directed answer.
    words_total = pending_words.size();
    queue_random_graph(1'b1);
    while (pending_words.size() < words_total + RANDOM_WORDS)
      queue_random_graph($urandom_range(0, 9) == 0);
    words_total = pending_words.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (words_sent < words_total || cycle_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
